// ----- rtl/core/tfm_pkg.sv -----
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared types and constants for the trigger frame matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package tfm_pkg;

    localparam int unsigned NUM_BITS_DEF     = 32;
    localparam int unsigned MAX_TRIGGERS_DEF = 1024;

    localparam int unsigned RUN_W   = 32;
    localparam int unsigned NUM_W   = 32;
    localparam int unsigned TRIG_W  = 11;
    localparam int unsigned SUM_W   = TRIG_W + 1;
    localparam int unsigned TDATA_W = 80;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [RUN_W-1:0]  run;
        logic [NUM_W-1:0]  num;
        logic [TRIG_W-1:0] trig;
    } tfm_item_t;

    typedef struct packed {
        logic              matched;
        logic [RUN_W-1:0]  run;
        logic [NUM_W-1:0]  num;
        logic [TRIG_W-1:0] trig;
        logic              last;
    } tfm_result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } tfm_queue_status_t;

    typedef enum logic [1:0] {
        FILL_NONE,
        FILL_ONE,
        FILL_TWO
    } fill_t;

    typedef enum logic {
        FR_EVAL,
        FR_SECOND
    } front_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/tfm_front.sv -----
// ----------------------------------------------------------------------------
// tfm_front
// Takes requests, holds the ID window and classifies each frame as matched
// or unmatched, pushing one result per cycle to the queue unless it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_front #(
    parameter int unsigned NUM_BITS     = tfm_pkg::NUM_BITS_DEF,
    parameter int unsigned MAX_TRIGGERS = tfm_pkg::MAX_TRIGGERS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire tfm_pkg::tfm_item_t        s_item,
    output logic                           push_valid,
    output tfm_pkg::tfm_result_t           push_data,
    input  wire tfm_pkg::tfm_queue_status_t q_status
);
    import tfm_pkg::*;

    logic              pend_valid_reg, pend_valid_next;
    tfm_item_t         pend_reg, pend_next;
    logic [RUN_W-1:0]  id0_run_reg, id0_run_next;
    logic [NUM_W-1:0]  id0_num_reg, id0_num_next;
    logic [RUN_W-1:0]  id1_run_reg, id1_run_next;
    logic [NUM_W-1:0]  id1_num_reg, id1_num_next;
    logic [TRIG_W-1:0] trig0_reg, trig0_next;
    fill_t             fill_reg, fill_next;
    front_state_t      state_reg, state_next;
    tfm_result_t       second_reg, second_next;

    logic                consume;
    logic [TRIG_W-1:0]   trig_sat;
    logic [NUM_BITS-1:0] diff_old;
    logic [NUM_BITS-1:0] diff_mid;
    logic [SUM_W-1:0]    sum_two;
    logic                match_one;
    logic                match_two;
    logic                match_mid;

    // saturate on arrival
    always_comb begin
        if ({21'd0, s_item.trig} > 32'(MAX_TRIGGERS)) begin
            trig_sat = TRIG_W'(MAX_TRIGGERS);
        end else begin
            trig_sat = s_item.trig;
        end
    end

    assign diff_old  = NUM_BITS'(pend_reg.num) - NUM_BITS'(id0_num_reg);
    assign diff_mid  = NUM_BITS'(pend_reg.num) - NUM_BITS'(id1_num_reg);
    assign sum_two   = {1'b0, trig0_reg} + {1'b0, pend_reg.trig};
    assign match_one = (pend_reg.run == id0_run_reg)
                    && (diff_old == NUM_BITS'({1'b0, pend_reg.trig}));
    assign match_two = (pend_reg.run == id0_run_reg) && (diff_old == NUM_BITS'(sum_two));
    assign match_mid = (pend_reg.run == id1_run_reg)
                    && (diff_mid == NUM_BITS'({1'b0, pend_reg.trig}));

    assign s_tready = !pend_valid_reg || consume;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_EVAL: begin
                if (pend_valid_reg && !q_status.full && (fill_reg == FILL_TWO)
                        && (match_two || match_mid)) begin
                    state_next = FR_SECOND;
                end
            end
            FR_SECOND: begin
                if (!q_status.full) begin
                    state_next = FR_EVAL;
                end
            end
            default: state_next = FR_EVAL;
        endcase
    end

    always_comb begin
        consume      = 1'b0;
        push_valid   = 1'b0;
        push_data    = '0;
        id0_run_next = id0_run_reg;
        id0_num_next = id0_num_reg;
        id1_run_next = id1_run_reg;
        id1_num_next = id1_num_reg;
        trig0_next   = trig0_reg;
        fill_next    = fill_reg;
        second_next  = second_reg;
        case (state_reg)
            FR_EVAL: begin
                if (pend_valid_reg && !q_status.full) begin
                    consume = 1'b1;
                    case (fill_reg)
                        FILL_ONE: begin
                            if (match_one) begin
                                push_valid   = 1'b1;
                                push_data    = '{1'b1, id0_run_reg, id0_num_reg,
                                                 pend_reg.trig, 1'b1};
                                id0_run_next = pend_reg.run;
                                id0_num_next = pend_reg.num;
                            end else begin
                                id1_run_next = pend_reg.run;
                                id1_num_next = pend_reg.num;
                                trig0_next   = pend_reg.trig;
                                fill_next    = FILL_TWO;
                            end
                        end
                        FILL_TWO: begin
                            push_valid = 1'b1;
                            if (match_two || match_mid) begin
                                push_data    = '{match_two, id0_run_reg, id0_num_reg,
                                                 trig0_reg, 1'b0};
                                second_next  = '{1'b1, id1_run_reg, id1_num_reg,
                                                 pend_reg.trig, 1'b1};
                                id0_run_next = pend_reg.run;
                                id0_num_next = pend_reg.num;
                                fill_next    = FILL_ONE;
                            end else begin
                                push_data    = '{1'b0, id0_run_reg, id0_num_reg,
                                                 trig0_reg, 1'b1};
                                id0_run_next = id1_run_reg;
                                id0_num_next = id1_num_reg;
                                id1_run_next = pend_reg.run;
                                id1_num_next = pend_reg.num;
                                trig0_next   = pend_reg.trig;
                            end
                        end
                        default: begin
                            id0_run_next = pend_reg.run;
                            id0_num_next = pend_reg.num;
                            fill_next    = FILL_ONE;
                        end
                    endcase
                end
            end
            FR_SECOND: begin
                if (!q_status.full) begin
                    push_valid = 1'b1;
                    push_data  = second_reg;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (s_tvalid && s_tready) begin
            pend_valid_next = 1'b1;
            pend_next       = '{s_item.run, s_item.num, trig_sat};
        end else if (consume) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            fill_reg       <= FILL_NONE;
            state_reg      <= FR_EVAL;
        end else begin
            pend_valid_reg <= pend_valid_next;
            fill_reg       <= fill_next;
            state_reg      <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg    <= pend_next;
        id0_run_reg <= id0_run_next;
        id0_num_reg <= id0_num_next;
        id1_run_reg <= id1_run_next;
        id1_num_reg <= id1_num_next;
        trig0_reg   <= trig0_next;
        second_reg  <= second_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/tfm_queue.sv -----
// ----------------------------------------------------------------------------
// tfm_queue
// Short result queue between classification and output.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push_valid,
    input  wire tfm_pkg::tfm_result_t push_data,
    input  wire logic                 pop,
    output tfm_pkg::tfm_result_t      head,
    output tfm_pkg::tfm_queue_status_t status
);
    import tfm_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    tfm_result_t      entry_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push      = push_valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tfm_back.sv -----
// ----------------------------------------------------------------------------
// tfm_back
// Drains the result queue into the output register and forms the first
// event number of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire tfm_pkg::tfm_result_t       head,
    input  wire tfm_pkg::tfm_queue_status_t q_status,
    output logic                            pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output tfm_pkg::tfm_result_t            m_result
);
    import tfm_pkg::*;

    logic        valid_reg, valid_next;
    tfm_result_t out_reg, out_next;

    assign pop = !q_status.empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        out_next   = out_reg;
        if (pop) begin
            valid_next = 1'b1;
            out_next   = '{head.matched, head.run, head.num + NUM_W'(1), head.trig, head.last};
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/trigger_frame_matcher_unit.sv -----
// A request waits in the pending register; its results pass the result queue, then the
// output register. Throughput: one request per cycle while the queue is not full and the
// request yields at most one result; two hold off the next via the single queue push port.
// Reset: aresetn is synchronous, active low; it clears the ID fill and all valid flags.
// Held IDs and trigger counts are not cleared and are written before they are read.
// ----------------------------------------------------------------------------
// trigger_frame_matcher_unit
// Pairs readout frames with the event IDs around them and reports each frame
// as matched or unmatched.
// ----------------------------------------------------------------------------
`default_nettype none

module trigger_frame_matcher_unit #(
    parameter int unsigned NUM_BITS     = tfm_pkg::NUM_BITS_DEF,
    parameter int unsigned MAX_TRIGGERS = tfm_pkg::MAX_TRIGGERS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // run_id[31:0], event_num[63:32], trigger_count[74:64], zero pad
    input  wire logic [tfm_pkg::TDATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // frame_run[31:0], first_number[63:32], frame_triggers[74:64], zero pad
    output logic [tfm_pkg::TDATA_W-1:0]      m_tdata,
    // matched[0]
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import tfm_pkg::*;

    tfm_item_t         s_item;
    logic              push_valid;
    tfm_result_t       push_data;
    tfm_result_t       head;
    tfm_queue_status_t q_status;
    logic              pop;
    tfm_result_t       m_result;

    assign s_item.run  = s_tdata[RUN_W-1:0];
    assign s_item.num  = s_tdata[RUN_W+NUM_W-1:RUN_W];
    assign s_item.trig = s_tdata[RUN_W+NUM_W+TRIG_W-1:RUN_W+NUM_W];

    tfm_front #(
        .NUM_BITS     (NUM_BITS),
        .MAX_TRIGGERS (MAX_TRIGGERS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_data  (push_data),
        .q_status   (q_status)
    );

    tfm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    tfm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {{(TDATA_W - RUN_W - NUM_W - TRIG_W){1'b0}},
                      m_result.trig, m_result.num, m_result.run};
    assign m_tuser = m_result.matched;
    assign m_tlast = m_result.last;

endmodule

`default_nettype wire

// ----- verif/trigger_frame_matcher_unit_tb.sv -----
// ----------------------------------------------------------------------------
// trigger_frame_matcher_unit_tb
// Drives event ID requests with their frame trigger counts into the matcher,
// predicts the matched and unmatched frames from a behavioral copy of the
// ID/frame window, and checks every result field in order. Directed corner
// requests come first, then random ID chains mixed with lost IDs, run
// changes and noise, under random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module trigger_frame_matcher_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tfm_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_RANDOM       = 1480;

    typedef struct {
        tfm_item_t it;
        bit        hold;
    } pend_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    pend_t       pending[$];
    tfm_result_t awaited[$];
    pend_t       cur_req;

    // window copy: held IDs oldest first, frame counts between them
    logic [RUN_W-1:0]  id_run[3];
    logic [NUM_W-1:0]  id_num[3];
    logic [TRIG_W-1:0] frame_trig[2];
    int                ids_held = 0;

    int  n_in        = 0;
    int  total_items = 0;
    int  since_in    = 0;
    int  stall       = 0;
    int  errors      = 0;
    int  s_gap       = 0;
    int  m_gap       = 0;
    int  hold_left   = 0;
    bit  held_once   = 1'b0;
    bit  s_took      = 1'b0;
    bit  m_took      = 1'b0;

    trigger_frame_matcher_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report(input string what, input longint got, input longint want);
        if (errors < 40) begin
            $display("mismatch %s: got %0h want %0h (request %0d)", what, got, want, n_in);
        end
        errors++;
    endtask

    task automatic match_frames(input tfm_item_t it);
        logic [TRIG_W-1:0] tc;
        logic [SUM_W-1:0]  sum;
        logic [NUM_W-1:0]  diff;
        tfm_result_t       res[4];
        int                n_out;
        int                newest;
        tc = (it.trig > TRIG_W'(MAX_TRIGGERS_DEF)) ? TRIG_W'(MAX_TRIGGERS_DEF) : it.trig;
        n_out = 0;
        if (ids_held == 0 || ids_held > 2) begin
            id_run[0] = it.run;
            id_num[0] = it.num;
            ids_held  = 1;
            return;
        end
        id_run[ids_held]       = it.run;
        id_num[ids_held]       = it.num;
        frame_trig[ids_held-1] = tc;
        ids_held++;
        while (ids_held > 1) begin
            newest = ids_held - 1;
            sum = '0;
            for (int k = 0; k < newest; k++) begin
                sum += SUM_W'(frame_trig[k]);
            end
            diff = id_num[newest] - id_num[0];
            if (id_run[newest] == id_run[0] && diff == {{(NUM_W-SUM_W){1'b0}}, sum}) begin
                for (int k = 0; k < newest; k++) begin
                    res[n_out] = '{matched: 1'b1, run: id_run[k], num: id_num[k] + NUM_W'(1),
                                   trig: frame_trig[k], last: 1'b0};
                    n_out++;
                end
                id_run[0] = id_run[newest];
                id_num[0] = id_num[newest];
                ids_held  = 1;
            end else if (ids_held == 3) begin
                res[n_out] = '{matched: 1'b0, run: id_run[0], num: id_num[0] + NUM_W'(1),
                               trig: frame_trig[0], last: 1'b0};
                n_out++;
                id_run[0]     = id_run[1];
                id_num[0]     = id_num[1];
                id_run[1]     = id_run[2];
                id_num[1]     = id_num[2];
                frame_trig[0] = frame_trig[1];
                ids_held      = 2;
            end else begin
                break;
            end
        end
        for (int k = 0; k < n_out; k++) begin
            res[k].last = (k == n_out - 1);
            awaited.insert(awaited.size(), res[k]);
        end
    endtask

    task automatic add_req(input logic [RUN_W-1:0] run, input logic [NUM_W-1:0] num,
                           input logic [TRIG_W-1:0] trig, input bit hold);
        pend_t p;
        p.it   = '{run: run, num: num, trig: trig};
        p.hold = hold;
        pending.insert(pending.size(), p);
    endtask

    function automatic bit idle_on();
        return (n_in + 200 < total_items) && ((n_in / 128) % 3 != 2);
    endfunction

    // sample both channels, predict on input, check on output
    always @(posedge aclk) begin : check_p
        tfm_result_t want;
        s_took = aresetn && s_tvalid && s_tready;
        m_took = aresetn && m_tvalid && m_tready;
        if (s_took) begin
            match_frames(cur_req.it);
            n_in++;
            since_in = 0;
        end else if (since_in < WATCHDOG_LIMIT) begin
            since_in++;
        end
        if (m_took) begin
            if (awaited.size() == 0) begin
                report("unexpected result, run", m_tdata[31:0], 0);
            end else begin
                want = awaited[0];
                awaited.delete(0);
                if (m_tuser !== want.matched) report("matched", m_tuser, want.matched);
                if (m_tdata[31:0] !== want.run) report("frame_run", m_tdata[31:0], want.run);
                if (m_tdata[63:32] !== want.num)
                    report("first_number", m_tdata[63:32], want.num);
                if (m_tdata[74:64] !== want.trig)
                    report("frame_triggers", m_tdata[74:64], want.trig);
                if (m_tlast !== want.last) report("last", m_tlast, want.last);
            end
        end
        if (!aresetn || s_took || m_took) begin
            stall = 0;
        end else begin
            stall++;
        end
    end

    always @(posedge aclk) begin
        if (stall >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // request driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_took)) begin
            if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap--;
            end else if (pending.size() > 0 &&
                         (!pending[0].hold || (awaited.size() == 0 && since_in >= 4))) begin
                cur_req = pending[0];
                pending.delete(0);
                s_tdata <= {{(TDATA_W-75){1'b0}}, cur_req.it.trig, cur_req.it.num,
                            cur_req.it.run};
                s_tvalid <= 1'b1;
                if (idle_on() && $urandom_range(0, 6) == 0) s_gap = $urandom_range(1, 4);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result ready, with one long hold-off to back up the block
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!held_once && n_in >= 400) begin
            m_tready <= 1'b0;
            hold_left = 63;
            held_once = 1'b1;
        end else if (m_gap > 0) begin
            m_tready <= 1'b0;
            m_gap--;
        end else begin
            m_tready <= 1'b1;
            if (idle_on() && $urandom_range(0, 5) == 0) m_gap = $urandom_range(1, 4);
        end
    end

    initial begin
        logic [RUN_W-1:0]  run;
        logic [NUM_W-1:0]  num;
        logic [TRIG_W-1:0] tc;
        logic [RUN_W-1:0]  chain_run;
        logic [NUM_W-1:0]  chain_num;
        logic [NUM_W-1:0]  acc;
        logic [TRIG_W-1:0] eff;
        int                pick;

        // first ID dropped, zero count, saturation, number wrap
        add_req(32'h0, 32'h0, 11'h7FF, 1'b0);
        add_req(32'h0, 32'h0, 11'h000, 1'b0);
        add_req(32'h0, 32'd1024, 11'h7FF, 1'b0);
        add_req(32'h0, 32'hFFFF_FFFF, 11'd5, 1'b0);
        add_req(32'h0, 32'd4, 11'd5, 1'b0);
        // run changes, unmatched then matched across three IDs
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1025, 1'b0);
        add_req(32'hFFFF_FFFF, 32'h3FF, 11'd1023, 1'b0);
        add_req(32'hFFFF_FFFF, 32'h3FF, 11'd1, 1'b0);
        add_req(32'hAAAA_AAAA, 32'h5555_5555, 11'h555, 1'b0);
        add_req(32'hAAAA_AAAA, 32'h5555_5555 + 32'h2AA, 11'h2AA, 1'b0);
        add_req(32'h5555_5555, 32'hAAAA_AAAA, 11'h000, 1'b0);
        add_req(32'h5555_5555, 32'hAAAA_AAAA, 11'h000, 1'b0);
        add_req(32'h0, 32'h0, 11'd1024, 1'b0);
        add_req(32'h0, 32'd1024, 11'd1024, 1'b0);
        add_req(32'h0, 32'd2048, 11'h7FF, 1'b0);
        add_req(32'h0, 32'd3000, 11'd1025, 1'b0);
        add_req(32'h0, 32'd3077, 11'd5, 1'b0);

        chain_run = $urandom;
        chain_num = $urandom;
        acc       = '0;
        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 99);
            tc   = ($urandom_range(0, 9) == 0) ? TRIG_W'($urandom_range(0, 2047))
                                                : TRIG_W'($urandom_range(0, 40));
            eff  = (tc > TRIG_W'(MAX_TRIGGERS_DEF)) ? TRIG_W'(MAX_TRIGGERS_DEF) : tc;
            if (pick < 70) begin
                run       = chain_run;
                num       = chain_num + acc + eff;
                chain_num = num;
                acc       = '0;
            end else if (pick < 85) begin
                // lost ID: its frame still counts toward the next window
                run = chain_run;
                num = $urandom;
                acc = acc + eff;
            end else if (pick < 92) begin
                run       = $urandom;
                num       = $urandom;
                chain_run = run;
                chain_num = num;
                acc       = '0;
            end else begin
                run = $urandom;
                num = $urandom;
                acc = acc + eff;
            end
            add_req(run, num, tc, (i == 0) || (i == 700));
        end
        total_items = pending.size();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_in < total_items || awaited.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && awaited.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
